FILE: rtl/jsv_pkg.sv
`default_nettype none

package jsv_pkg;

	// Phase codes of the text scan.
	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;
	localparam logic [1:0] PH_FAIL = 2'd3;

	// Characters with a structural meaning.
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	// Command to the row of stack cells; push_bit is 1 for an expected brace.
	typedef struct packed {
		logic push;
		logic pop;
		logic push_bit;
	} stack_op_t;

	// Result handed from the scanner to the output stage.
	typedef struct packed {
		logic fire;
		logic is_valid;
	} verdict_t;

	// Whitespace: space, tab, LF, VT, FF, CR.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

`default_nettype wire

FILE: rtl/json_structure_validator_top.sv
// JSON structure validator. Bytes of one text enter on the slave stream, one
// item per cycle, with tlast on the final byte; after a last byte a single
// result item (bit 0 of m_tdata: 1 if the text is exactly one well-formed
// object by its braces, brackets and strings) leaves on the master stream.
// The expected closers live in a row of MAX_NEST one-bit cells that shift down
// on an opener and up on a closer, so the check of a closer is a compare against
// the first cell. Results pass a two-entry output stage, so input is held back
// only when two verdicts wait untaken. No clearing pass is needed after reset or
// between texts.
`default_nettype none

module json_structure_validator_top #(
	parameter int MAX_NEST = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_byte
	input  wire logic       s_tlast,   // is_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata    // [0] is_valid, [7:1] zero
);
	import jsv_pkg::*;

	localparam int LVL_W = $clog2(MAX_NEST + 1);

	logic             accept;
	stack_op_t        op;
	verdict_t         verdict;
	logic [LVL_W-1:0] level;
	logic [MAX_NEST-1:0] cells;
	logic             out_v_q, out_d_q;
	logic             sk_v_q, sk_d_q;
	logic             out_pop;

	assign s_tready = !sk_v_q;
	assign accept   = s_tvalid && s_tready;

	// Byte scanner.
	jsv_ctrl #(
		.MAX_NEST(MAX_NEST),
		.LVL_W   (LVL_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.text_byte(s_tdata),
		.is_last  (s_tlast),
		.top_bit  (cells[0]),
		.op       (op),
		.verdict  (verdict),
		.level    (level)
	);

	// Row of closer cells; cell 0 is the top of the stack.
	for (genvar i = 0; i < MAX_NEST; i++) begin : g_cell
		logic above, below;
		if (i == 0) begin : g_first
			assign above = op.push_bit;
		end else begin : g_mid
			assign above = cells[i-1];
		end
		if (i == MAX_NEST - 1) begin : g_end
			assign below = 1'b0;
		end else begin : g_inner
			assign below = cells[i+1];
		end
		jsv_cell u_cell (
			.clk       (clk),
			.op        (op),
			.from_above(above),
			.from_below(below),
			.bit_q     (cells[i])
		);
	end

	// Output register with a skid entry behind it.
	assign out_pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (out_pop || !out_v_q) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= verdict.fire;
			end else begin
				out_v_q <= verdict.fire;
			end
		end else if (verdict.fire) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop || !out_v_q) begin
			if (sk_v_q) begin
				out_d_q <= sk_d_q;
				sk_d_q  <= verdict.is_valid;
			end else begin
				out_d_q <= verdict.is_valid;
			end
		end else if (verdict.fire) begin
			sk_d_q <= verdict.is_valid;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_d_q};

	// The skid entry is only filled behind a waiting result.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry holds a result while the output register is empty");

	// A new result only follows an accepted last byte.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
		else $error("result appeared without a last byte");

	// Nesting never passes the stack depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LVL_W'(MAX_NEST))
		else $error("nesting level beyond stack depth");

	// A text end leaves the stack empty.
	a_level_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (level == '0))
		else $error("nesting level not cleared after last byte");

endmodule

`default_nettype wire

FILE: rtl/jsv_cell.sv
`default_nettype none

module jsv_cell (
	input  wire logic              clk,
	input  wire jsv_pkg::stack_op_t op,
	input  wire logic              from_above,
	input  wire logic              from_below,
	output logic                   bit_q
);
	import jsv_pkg::*;

	// A push moves every entry one cell deeper, a pop one cell up.
	always_ff @(posedge clk) begin
		if (op.push) begin
			bit_q <= from_above;
		end else if (op.pop) begin
			bit_q <= from_below;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/jsv_ctrl.sv
`default_nettype none

module jsv_ctrl #(
	parameter int MAX_NEST = 256,
	parameter int LVL_W    = 9
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         text_byte,
	input  wire logic               is_last,
	input  wire logic               top_bit,
	output jsv_pkg::stack_op_t      op,
	output jsv_pkg::verdict_t       verdict,
	output logic [LVL_W-1:0]        level
);
	import jsv_pkg::*;

	logic [1:0]       phase_q, phase_d;
	logic             quote_q, quote_d;
	logic             bslash_q, bslash_d;
	logic [LVL_W-1:0] level_q, level_d;
	logic             push, pop, push_bit;
	logic             want_brace;

	// Next state of the scan for the current byte.
	always_comb begin
		phase_d    = phase_q;
		quote_d    = quote_q;
		bslash_d   = bslash_q;
		push       = 1'b0;
		pop        = 1'b0;
		push_bit   = 1'b0;
		want_brace = (text_byte == CH_RBRACE);
		case (phase_q)
			PH_LEAD: begin
				if (!is_ws(text_byte)) begin
					if (text_byte == CH_LBRACE) begin
						phase_d  = PH_BODY;
						push     = 1'b1;
						push_bit = 1'b1;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_BODY: begin
				if (quote_q) begin
					if (bslash_q) begin
						bslash_d = 1'b0;
					end else if (text_byte == CH_BACKSLASH) begin
						bslash_d = 1'b1;
					end else if (text_byte == CH_QUOTE) begin
						quote_d = 1'b0;
					end
				end else if (text_byte == CH_QUOTE) begin
					quote_d = 1'b1;
				end else if (text_byte == CH_LBRACE || text_byte == CH_LBRACKET) begin
					if (level_q == LVL_W'(MAX_NEST)) begin
						phase_d = PH_FAIL;
					end else begin
						push     = 1'b1;
						push_bit = (text_byte == CH_LBRACE);
					end
				end else if (text_byte == CH_RBRACE || text_byte == CH_RBRACKET) begin
					if (level_q == '0 || top_bit != want_brace) begin
						phase_d = PH_FAIL;
					end else begin
						pop = 1'b1;
						if (level_q == LVL_W'(1)) begin
							phase_d = PH_TAIL;
						end
					end
				end
			end
			PH_TAIL: begin
				if (!is_ws(text_byte)) begin
					phase_d = PH_FAIL;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		if (push) begin
			level_d = level_q + LVL_W'(1);
		end else if (pop) begin
			level_d = level_q - LVL_W'(1);
		end else begin
			level_d = level_q;
		end
	end

	// Scan state; a last byte returns everything to the start of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			quote_q  <= 1'b0;
			bslash_q <= 1'b0;
			level_q  <= '0;
		end else if (accept) begin
			if (is_last) begin
				phase_q  <= PH_LEAD;
				quote_q  <= 1'b0;
				bslash_q <= 1'b0;
				level_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				quote_q  <= quote_d;
				bslash_q <= bslash_d;
				level_q  <= level_d;
			end
		end
	end

	// Stack command and verdict only for an accepted item.
	assign op.push          = accept && push;
	assign op.pop           = accept && pop;
	assign op.push_bit      = push_bit;
	assign verdict.fire     = accept && is_last;
	assign verdict.is_valid = (phase_d == PH_TAIL);
	assign level            = level_q;

endmodule

`default_nettype wire
